>>> sv/tmf_pkg.sv
// -----------------------------------------------------------------------------
// tmf_pkg
// Shared widths, limits and control types of the trimmed-mean sample filter.
// -----------------------------------------------------------------------------
package tmf_pkg;

    // Width of one converter sample and of the count register.
    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_W     = 8;

    // The block sum holds up to 256 full-scale samples without wrapping.
    localparam int SUM_W  = SAMPLE_BITS + COUNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    // Clamp limits of the averaged count and the number of dropped samples.
    localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(253);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);
    localparam logic [COUNT_W:0]   DROPPED     = (COUNT_W + 1)'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accum;     // take the offered sample into the block
        logic load;      // form the trimmed sum and start the divider
        logic step;      // one restoring division step
        logic out_load;  // move the quotient into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_end; // the offered sample completes the block
    } t_status;

endpackage

>>> sv/trimmed_mean_sample_filter.sv
// -----------------------------------------------------------------------------
// trimmed_mean_sample_filter
// Trimmed mean of blocks of converter samples, largest and smallest dropped.
// -----------------------------------------------------------------------------
// Usage:
// Samples enter on i_sample with i_valid/o_ready; a transfer takes place when
// both are high. Averages leave on o_average with o_valid/i_ready. A block is
// sample_count+2 samples (count 0 acts as 1, counts above 253 act as 253);
// the count is written through i_cfg_we/i_cfg_data and is 8 after reset.
// Samples inside a block are taken one per cycle. The sample that completes
// a block starts the mean: the LOAD state forms the trimmed sum, the
// restoring divider then runs in the DIV state (one quotient bit per cycle),
// and the HOLD state moves the quotient into the output register once that
// register is free, raising o_valid. o_ready stays low until that move. The
// output register decouples the two sides: new samples are accepted while
// a result waits, and a finished quotient waits in the divider while the
// previous result is still stalled by the receiver.
// Reset (synchronous, active low) clears the block, the output valid flag and
// restores the count.
// -----------------------------------------------------------------------------
module trimmed_mean_sample_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmf_pkg::COUNT_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tmf_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tmf_pkg::SAMPLE_BITS-1:0] o_average
);

    tmf_pkg::t_cmd    cmd;
    tmf_pkg::t_status status;

    // Sequencing and handshakes.
    tmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Accumulation, division and output storage.
    tmf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_average  (o_average)
    );

endmodule

>>> sv/tmf_ctrl.sv
// -----------------------------------------------------------------------------
// tmf_ctrl
// Controller: input and output handshakes, division step count and sequencing.
// -----------------------------------------------------------------------------
module tmf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  tmf_pkg::t_status i_status,
    output tmf_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam logic [tmf_pkg::STEP_W-1:0] LAST_STEP =
        tmf_pkg::STEP_W'(tmf_pkg::SUM_W - 1);

    logic [1:0]                 r_state, n_state;
    logic [tmf_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_out_valid, n_out_valid;
    logic                       in_xfer;
    logic                       out_free;

    // Samples are taken only while no division is in flight.
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign in_xfer  = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_ready;

    // Next state, step count and commands.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.accum  = in_xfer;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_status.block_end) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_HOLD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/tmf_dp.sv
// -----------------------------------------------------------------------------
// tmf_dp
// Datapath: count register, block sum and extremes, restoring divider and the
// output register.
// -----------------------------------------------------------------------------
module tmf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmf_pkg::COUNT_W-1:0]     i_cfg_data,
    input  logic [tmf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  tmf_pkg::t_cmd                   i_cmd,
    output tmf_pkg::t_status                o_status,
    output logic [tmf_pkg::SAMPLE_BITS-1:0] o_average
);

    localparam int SB = tmf_pkg::SAMPLE_BITS;
    localparam int CW = tmf_pkg::COUNT_W;
    localparam int SW = tmf_pkg::SUM_W;

    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic [SB-1:0] r_max;
    logic [SB-1:0] r_min;
    logic [CW-1:0] r_taken;
    logic [CW-1:0] r_div_n;
    logic [SW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [SB-1:0] r_average;

    logic [CW-1:0] eff_n;
    logic          first;
    logic [SB-1:0] n_max;
    logic [SB-1:0] n_min;
    logic [SW-1:0] n_sum;
    logic [CW:0]   n_taken;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_diff;
    logic          rem_ge;

    // Effective count: zero acts as the minimum, large values are capped.
    always_comb begin
        eff_n = r_count;
        if (r_count < tmf_pkg::COUNT_MIN) begin
            eff_n = tmf_pkg::COUNT_MIN;
        end else if (r_count > tmf_pkg::COUNT_MAX) begin
            eff_n = tmf_pkg::COUNT_MAX;
        end
    end

    // Block statistics updated with the offered sample.
    always_comb begin
        first   = (r_taken == '0);
        n_max   = (first || (i_sample > r_max)) ? i_sample : r_max;
        n_min   = (first || (i_sample < r_min)) ? i_sample : r_min;
        n_sum   = r_sum + SW'(i_sample);
        n_taken = {1'b0, r_taken} + 1'b1;
    end

    assign o_status.block_end = (n_taken >= ({1'b0, eff_n} + tmf_pkg::DROPPED));

    // One restoring division step: shift in the next dividend bit, then
    // subtract the divisor when it fits.
    always_comb begin
        rem_sh   = {r_rem, r_quo[SW-1]};
        rem_ge   = (rem_sh >= {1'b0, r_div_n});
        rem_diff = rem_sh - {1'b0, r_div_n};
    end

    // Count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= tmf_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // Block state: sum, extremes and sample count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_taken <= '0;
        end else if (i_cmd.accum) begin
            r_sum   <= n_sum;
            r_max   <= n_max;
            r_min   <= n_min;
            r_taken <= o_status.block_end ? '0 : n_taken[CW-1:0];
        end else if (i_cmd.load) begin
            r_sum   <= '0;
            r_max   <= '0;
            r_min   <= '0;
        end
    end

    // Divider registers; the divisor is the count in force at block end.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && o_status.block_end) begin
            r_div_n <= eff_n;
        end
        if (i_cmd.load) begin
            r_quo <= r_sum - SW'(r_max) - SW'(r_min);
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SW-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_average <= r_quo[SB-1:0];
        end
    end

    assign o_average = r_average;

endmodule

>>> sv/tmf_checker.sv
// -----------------------------------------------------------------------------
// tmf_checker
// Port-level checks of the trimmed-mean sample filter, bound to the top level.
// -----------------------------------------------------------------------------
module tmf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [tmf_pkg::SAMPLE_BITS-1:0] o_average
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average))
        else $error("stalled result changed or dropped");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Ready drops only after a sample transfer.
    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !i_valid |=> o_ready)
        else $error("ready dropped without a transfer");

    // A new result never follows a sample transfer in the next cycle.
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared right after a sample transfer");

endmodule

bind trimmed_mean_sample_filter tmf_checker u_tmf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_average (o_average)
);
